### hw/rtl/dmc_pkg.sv
// Shared types, codes and helper functions for the depth-first maze carver.
package dmc_pkg;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_STEP  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [1:0] ST_STARTED = 2'd0;
	localparam logic [1:0] ST_CARVED  = 2'd1;
	localparam logic [1:0] ST_IDLE    = 2'd2;
	localparam logic [1:0] ST_READ    = 2'd3;

	localparam logic [3:0] DIR_N = 4'd1;
	localparam logic [3:0] DIR_E = 4'd2;
	localparam logic [3:0] DIR_S = 4'd4;
	localparam logic [3:0] DIR_W = 4'd8;

	localparam logic CFG_COLUMNS = 1'b0;
	localparam logic CFG_ROWS    = 1'b1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_EVAL,
		S_POP,
		S_CARVE,
		S_RDATA,
		S_DONE
	} dmc_state_t;

	// Residue of an eight-bit value modulo three, folding base-four digits.
	function automatic logic [1:0] dmc_mod3(input logic [7:0] v);
		logic [3:0] s1;
		logic [2:0] s2;
		logic [2:0] s3;
		s1 = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
		s2 = 3'(s1[3:2]) + 3'(s1[1:0]);
		s3 = 3'(s2[2]) + 3'(s2[1:0]);
		if (s3 >= 3'd3) begin
			s3 = s3 - 3'd3;
		end
		return s3[1:0];
	endfunction

	// Rank of the chosen direction: the pick value modulo the count of legal ones.
	function automatic logic [1:0] dmc_rank(input logic [7:0] pick, input logic [2:0] cnt);
		logic [1:0] k;
		case (cnt)
			3'd1: k = 2'd0;
			3'd2: k = {1'b0, pick[0]};
			3'd3: k = dmc_mod3(pick);
			default: k = pick[1:0];
		endcase
		return k;
	endfunction

	// The k-th set bit of the legal mask, counted from north.
	function automatic logic [3:0] dmc_pick_dir(input logic [3:0] dirs, input logic [1:0] k);
		logic [3:0] mv;
		logic [2:0] seen;
		mv = '0;
		seen = '0;
		for (int b = 0; b < 4; b++) begin
			if (dirs[b]) begin
				if (seen == {1'b0, k} && mv == '0) begin
					mv[b] = 1'b1;
				end
				seen = seen + 3'd1;
			end
		end
		return mv;
	endfunction

endpackage

### hw/rtl/dmc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module dmc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/dfs_maze_carver.sv
// Top level of the depth-first maze carver with grid and backtrack-stack memories.
//
// The maze lives in a grid RAM of 4-bit opening masks addressed by row and column, and
// the backtrack stack in a second RAM of MAX_SIDE squared entries; one item is handled
// at a time. After reset the grid RAM is swept to zero, one entry a cycle, over all
// 2**(2*clog2(MAX_SIDE)) entries (4096 at the default) before the first input beat is
// taken; configuration beats are taken throughout. A start item runs the same sweep
// before it reports. In a carving step the current cell and its four neighbours are
// read one a cycle through the single grid read port, then the two walls are written
// one a cycle. Each cell popped while backtracking adds a stack read and the five
// grid reads. A read item passes through a grid-read state before the result state.
// A result waits in an output register, so the next input beat can be taken while it
// is still held.
module dfs_maze_carver
	import dmc_pkg::*;
#(
	parameter int MAX_SIDE = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [5:0]  start_row,
	input  logic [5:0]  start_col,
	input  logic [7:0]  rand_pick,
	input  logic [5:0]  read_row,
	input  logic [5:0]  read_col,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [5:0]  cur_row,
	output logic [5:0]  cur_col,
	output logic [3:0]  carved_dir,
	output logic [3:0]  cell_openings,
	output logic [12:0] stack_depth,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data
);

	localparam int CW       = $clog2(MAX_SIDE);
	localparam int SW       = $clog2(MAX_SIDE + 1);
	localparam int XW       = SW + 7;
	localparam int GAW      = 2 * CW;
	localparam int GDEPTH   = 1 << GAW;
	localparam int CELLS    = MAX_SIDE * MAX_SIDE;
	localparam int SAW      = $clog2(CELLS);
	localparam int SPW      = $clog2(CELLS + 1);
	localparam int RST_SIDE = (MAX_SIDE < 8) ? MAX_SIDE : 8;

	dmc_state_t state_q, state_d;

	logic [SW-1:0]  cols_q, rows_q;
	logic [SW-1:0]  cfg_eff;
	logic [CW-1:0]  cur_r_q, cur_c_q;
	logic [SPW-1:0] sp_q;
	logic [SPW-1:0] sp_m1;
	logic           finished_q;
	logic [GAW-1:0] clr_q;
	logic           clr_report_q;
	logic [2:0]     look_q;
	logic           out_valid_q;

	logic [3:0]     cmask_q;
	logic [3:0]     zero_q;
	logic [3:0]     move_q;
	logic [7:0]     pick_q;
	logic           in_range_q;
	logic [1:0]     res_status_q;
	logic [3:0]     res_dir_q;
	logic [3:0]     res_open_q;
	logic [1:0]     status_q;
	logic [5:0]     cur_row_q, cur_col_q;
	logic [3:0]     carved_dir_q, cell_openings_q;
	logic [12:0]    stack_depth_q;

	logic           g_we;
	logic [GAW-1:0] g_waddr, g_raddr;
	logic [3:0]     g_wdata, g_rdata;
	logic           s_we;
	logic [GAW-1:0] s_rdata;

	logic [XW-1:0]  r_x, c_x, rows_x, cols_x;
	logic [3:0]     nb_ok;
	logic [3:0]     dirs;
	logic [3:0]     mv;
	logic [GAW-1:0] cur_addr;
	logic [GAW-1:0] naddr [4];
	logic [GAW-1:0] carve_addr;
	logic           accept;
	logic           push_ok;
	logic           rd_in_range;
	logic           out_free;

	// Side length of a config beat: zero counts as one, values over MAX_SIDE as MAX_SIDE.
	always_comb begin
		if (cfg_data == '0) begin
			cfg_eff = SW'(1);
		end else if (XW'(cfg_data) > XW'(MAX_SIDE)) begin
			cfg_eff = SW'(MAX_SIDE);
		end else begin
			cfg_eff = SW'(cfg_data);
		end
	end

	assign r_x    = XW'(cur_r_q);
	assign c_x    = XW'(cur_c_q);
	assign rows_x = XW'(rows_q);
	assign cols_x = XW'(cols_q);

	assign nb_ok[0] = (cur_r_q != '0) && (r_x - XW'(1) < rows_x) && (c_x < cols_x);
	assign nb_ok[1] = (r_x < rows_x) && (c_x + XW'(1) < cols_x);
	assign nb_ok[2] = (r_x + XW'(1) < rows_x) && (c_x < cols_x);
	assign nb_ok[3] = (cur_c_q != '0) && (r_x < rows_x) && (c_x - XW'(1) < cols_x);

	assign dirs = nb_ok & zero_q;
	assign mv   = dmc_pick_dir(dirs, dmc_rank(pick_q, 3'($countones(dirs))));

	assign cur_addr = {cur_r_q, cur_c_q};
	assign naddr[0] = {cur_r_q - CW'(1), cur_c_q};
	assign naddr[1] = {cur_r_q, cur_c_q + CW'(1)};
	assign naddr[2] = {cur_r_q + CW'(1), cur_c_q};
	assign naddr[3] = {cur_r_q, cur_c_q - CW'(1)};

	always_comb begin
		case (move_q)
			DIR_N: carve_addr = naddr[0];
			DIR_E: carve_addr = naddr[1];
			DIR_S: carve_addr = naddr[2];
			default: carve_addr = naddr[3];
		endcase
	end

	assign sp_m1       = sp_q - SPW'(1);
	assign accept      = in_valid && in_ready;
	assign push_ok     = sp_q < SPW'(CELLS);
	assign rd_in_range = (XW'(read_row) < rows_x) && (XW'(read_col) < cols_x);
	assign out_free    = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == '1) begin
					state_d = clr_report_q ? S_DONE : S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					case (op)
						OP_START: state_d = S_CLEAR;
						OP_STEP:  state_d = finished_q ? S_DONE : S_LOOK;
						OP_READ:  state_d = S_RDATA;
						default:  state_d = S_DONE;
					endcase
				end
			end
			S_LOOK: begin
				if (look_q == 3'd5) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (dirs != '0) begin
					state_d = S_CARVE;
				end else if (sp_q != '0) begin
					state_d = S_POP;
				end else begin
					state_d = S_DONE;
				end
			end
			S_POP:   state_d = S_LOOK;
			S_CARVE: state_d = S_DONE;
			S_RDATA: state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		g_we     = 1'b0;
		g_waddr  = cur_addr;
		g_wdata  = '0;
		g_raddr  = cur_addr;
		s_we     = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				g_we    = 1'b1;
				g_waddr = clr_q;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				g_raddr  = {CW'(read_row), CW'(read_col)};
				s_we     = in_valid && (op == OP_STEP) && !finished_q && push_ok;
			end
			S_LOOK: begin
				if (look_q != 3'd0) begin
					g_raddr = naddr[2'(look_q - 3'd1)];
				end
			end
			S_EVAL: begin
				g_we    = dirs != '0;
				g_wdata = cmask_q | mv;
			end
			S_POP: begin
			end
			S_CARVE: begin
				g_we    = 1'b1;
				g_waddr = carve_addr;
				g_wdata = {move_q[1:0], move_q[3:2]};
			end
			S_RDATA: begin
			end
			S_DONE: begin
			end
		endcase
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			cols_q       <= SW'(RST_SIDE);
			rows_q       <= SW'(RST_SIDE);
			cur_r_q      <= '0;
			cur_c_q      <= '0;
			sp_q         <= '0;
			finished_q   <= 1'b1;
			clr_q        <= '0;
			clr_report_q <= 1'b0;
			look_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_COLUMNS: cols_q <= cfg_eff;
					CFG_ROWS:    rows_q <= cfg_eff;
				endcase
			end
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + GAW'(1);
			end
			if (accept) begin
				look_q <= '0;
				if (op == OP_START) begin
					sp_q         <= '0;
					finished_q   <= 1'b0;
					clr_q        <= '0;
					clr_report_q <= 1'b1;
					cur_r_q      <= (XW'(start_row) < rows_x) ? CW'(start_row)
						: CW'(rows_q - SW'(1));
					cur_c_q      <= (XW'(start_col) < cols_x) ? CW'(start_col)
						: CW'(cols_q - SW'(1));
				end else if (op == OP_STEP && !finished_q && push_ok) begin
					sp_q <= sp_q + SPW'(1);
				end
			end
			if (state_q == S_LOOK) begin
				look_q <= look_q + 3'd1;
			end
			if (state_q == S_EVAL && dirs == '0) begin
				if (sp_q != '0) begin
					sp_q <= sp_m1;
				end else begin
					finished_q <= 1'b1;
				end
			end
			if (state_q == S_POP) begin
				cur_r_q <= s_rdata[GAW-1:CW];
				cur_c_q <= s_rdata[CW-1:0];
				look_q  <= '0;
			end
			if (state_q == S_CARVE) begin
				case (move_q)
					DIR_N: cur_r_q <= cur_r_q - CW'(1);
					DIR_E: cur_c_q <= cur_c_q + CW'(1);
					DIR_S: cur_r_q <= cur_r_q + CW'(1);
					default: cur_c_q <= cur_c_q - CW'(1);
				endcase
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_dir_q  <= '0;
			res_open_q <= '0;
			in_range_q <= rd_in_range;
			pick_q     <= rand_pick;
			case (op)
				OP_START: res_status_q <= ST_STARTED;
				OP_READ:  res_status_q <= ST_READ;
				default:  res_status_q <= ST_IDLE;
			endcase
		end
		if (state_q == S_LOOK) begin
			if (look_q == 3'd1) begin
				cmask_q <= g_rdata;
			end else if (look_q != 3'd0) begin
				zero_q[2'(look_q - 3'd2)] <= (g_rdata == '0);
			end
		end
		if (state_q == S_EVAL && dirs != '0) begin
			move_q       <= mv;
			res_dir_q    <= mv;
			res_status_q <= ST_CARVED;
		end
		if (state_q == S_RDATA) begin
			res_open_q <= in_range_q ? g_rdata : '0;
		end
		if (state_q == S_DONE && out_free) begin
			status_q        <= res_status_q;
			cur_row_q       <= 6'(cur_r_q);
			cur_col_q       <= 6'(cur_c_q);
			carved_dir_q    <= res_dir_q;
			cell_openings_q <= res_open_q;
			stack_depth_q   <= 13'(sp_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign cur_row       = cur_row_q;
	assign cur_col       = cur_col_q;
	assign carved_dir    = carved_dir_q;
	assign cell_openings = cell_openings_q;
	assign stack_depth   = stack_depth_q;

	dmc_ram #(
		.WIDTH(4),
		.DEPTH(GDEPTH)
	) u_grid (
		.clk  (clk),
		.we   (g_we),
		.waddr(g_waddr),
		.wdata(g_wdata),
		.raddr(g_raddr),
		.rdata(g_rdata)
	);

	dmc_ram #(
		.WIDTH(GAW),
		.DEPTH(CELLS)
	) u_stack (
		.clk  (clk),
		.we   (s_we),
		.waddr(sp_q[SAW-1:0]),
		.wdata(cur_addr),
		.raddr(sp_m1[SAW-1:0]),
		.rdata(s_rdata)
	);

endmodule
